// ----- design/sha256_message_hash_core_defines.svh -----
// Assertion macros for the SHA-256 message hash core.
// Used by the core modules; no other dependencies.
`ifndef SHA256_MESSAGE_HASH_CORE_DEFINES_SVH
`define SHA256_MESSAGE_HASH_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define SHA_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SHA_ASSERT(label, clk, rst, prop)
`define SHA_ASSERT_RST(label, clk, prop)
`endif
`endif

// ----- design/sha_pkg.sv -----
// Package for the SHA-256 message hash core: constants, round table and functions.
// No dependencies.
package sha_pkg;
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_LOAD  = 4'd1;
  localparam logic [3:0] ST_ROUND = 4'd2;
  localparam logic [3:0] ST_ADD   = 4'd3;
  localparam logic [3:0] ST_PAD   = 4'd4;
  localparam logic [3:0] ST_OUT   = 4'd5;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef logic [31:0] word_t;
  typedef logic [60:0] count_t;

  typedef struct packed {
    logic  start;
    logic  step;
    logic  add;
    logic  init;
  } rnd_ctl_t;

  function automatic word_t iv(input logic [2:0] i);
    case (i)
      3'd0: iv = 32'h6a09e667; 3'd1: iv = 32'hbb67ae85;
      3'd2: iv = 32'h3c6ef372; 3'd3: iv = 32'ha54ff53a;
      3'd4: iv = 32'h510e527f; 3'd5: iv = 32'h9b05688c;
      3'd6: iv = 32'h1f83d9ab; default: iv = 32'h5be0cd19;
    endcase
  endfunction

  function automatic word_t round_k(input logic [5:0] t);
    logic [31:0] k [64];
    k = '{32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
          32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
          32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
          32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
          32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
          32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
          32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
          32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
          32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
          32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
          32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
    round_k = k[t];
  endfunction

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction
endpackage

// ----- design/sha_if.sv -----
// Valid/ready stream interfaces for the SHA-256 core.
// No dependencies.
interface sha_in_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       carries_byte;
  logic       end_of_message;
  modport source (output valid, data_byte, carries_byte, end_of_message, input ready);
  modport sink (input valid, data_byte, carries_byte, end_of_message, output ready);
endinterface

interface sha_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_number;
  logic        final_word;
  modport source (output valid, digest_word, word_number, final_word, input ready);
  modport sink (input valid, digest_word, word_number, final_word, output ready);
endinterface

// ----- design/sha_round.sv -----
// SHA-256 round unit: working variables, rolling schedule, chain value.
// Depends on sha_pkg.
`include "sha256_message_hash_core_defines.svh"
module sha_round import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  rnd_ctl_t    ctl,
  input  logic [5:0]  t,
  input  word_t       w_in,
  input  logic [2:0]  hsel,
  output word_t       hout
);
  word_t chain [8];
  word_t v [8];
  word_t sched [16];
  word_t w, x15, x2, t1, t2;

  always_comb begin
    x15 = sched[4'(t - 6'd15)];
    x2  = sched[4'(t - 6'd2)];
    if (t < 6'd16) begin
      w = w_in;
    end else begin
      w = sched[t[3:0]] + (rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3)) +
          sched[4'(t - 6'd7)] + (rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10));
    end
    t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
         ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(t) + w;
    t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
         ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.init) begin
      for (int i = 0; i < 8; i++) chain[i] <= iv(3'(i));
    end else if (ctl.add) begin
      for (int i = 0; i < 8; i++) chain[i] <= chain[i] + v[i];
    end
    if (ctl.start) begin
      for (int i = 0; i < 8; i++) v[i] <= chain[i];
    end else if (ctl.step) begin
      sched[t[3:0]] <= w;
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
    end
  end

  assign hout = chain[hsel];

  `SHA_ASSERT(a_ctl_excl, clk, rst, $onehot0({ctl.start, ctl.step, ctl.add}))
  `SHA_ASSERT(a_add_after_step, clk, rst, ctl.add |-> $past(ctl.step))
  `SHA_ASSERT(a_init_chain, clk, rst, $past(ctl.init) && !$past(rst) |-> chain[0] == 32'h6a09e667)
endmodule

// ----- design/sha256_message_hash_core.sv -----
// SHA-256 message hash core, top level: byte buffer, padding and round sequencer.
// Depends on sha_pkg, sha_if, sha_round.
//
// Usage: requests on in_ch carry one optional message byte and an end flag.
// A request with carries_byte=0, end_of_message=0 is a no-op.
// in_ch.ready is high in the idle state, so requests that neither complete a
// 64-byte block nor end the message are taken back to back, one per cycle.
// A byte that completes a block starts one compression: a load, 64 rounds
// and an add, all on the single shared round unit; in_ch.ready stays low
// meanwhile. An end request pads the message: a fill step writes each byte
// from the 0x80 marker to byte 63, then a compression follows. When the
// marker lands in bytes 56..63, or the final byte fills the block, a second
// block follows, filled in full. The eight digest words then go out on out_ch,
// word 0 first, final_word on word 7, at most one per cycle. Each word waits
// for out_ch.ready; a stalled receiver holds the block in the output state.
// After the last word the chain and byte count return to initial values.
// Reset (rst, synchronous) clears the sequencer, byte count and chain value.
// The byte buffer holds no reset value; it is always written before read.
`include "sha256_message_hash_core_defines.svh"
module sha256_message_hash_core import sha_pkg::*; (
  input logic clk,
  input logic rst,
  sha_in_if.sink    in_ch,
  sha_out_if.source out_ch
);
  logic [3:0] state, state_next;
  word_t      buf_mem [16];
  count_t     count;
  logic [6:0] ptr;
  logic [6:0] t;
  logic       final_pass, second, eom;
  logic [2:0] oidx;
  rnd_ctl_t   ctl;
  word_t      w_in, hout;
  logic [63:0] bits;
  logic [7:0] pad_val;
  logic [5:0] mark_pos;
  logic [3:0] rd_addr;

  assign bits = {count, 3'b000};
  assign mark_pos = count[5:0] + {5'd0, in_ch.carries_byte};
  assign rd_addr = (state == ST_LOAD) ? 4'd0 : t[3:0] + 4'd1;

  always_comb begin
    if (ptr[5:0] >= 6'd56 && !second) pad_val = bits[{~ptr[2:0], 3'b111} -: 8];
    else if (ptr[5:0] == count[5:0]) pad_val = PAD_BYTE;
    else pad_val = 8'd0;
  end

  always_ff @(posedge clk) begin
    w_in <= buf_mem[rd_addr];
  end

  sha_round u_round (.clk, .rst, .ctl, .t(t[5:0]), .w_in, .hsel(oidx), .hout);

  assign in_ch.ready = (state == ST_IDLE);
  assign out_ch.valid = (state == ST_OUT);
  assign out_ch.digest_word = hout;
  assign out_ch.word_number = oidx;
  assign out_ch.final_word = (oidx == 3'd7);

  always_comb begin
    ctl = '0;
    ctl.start = (state == ST_LOAD);
    ctl.step  = (state == ST_ROUND);
    ctl.add   = (state == ST_ADD);
    ctl.init  = (state == ST_OUT) && out_ch.ready && (oidx == 3'd7);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_ch.valid) begin
        if (in_ch.carries_byte && count[5:0] == 6'd63) state_next = ST_LOAD;
        else if (in_ch.end_of_message) state_next = ST_PAD;
      end
      ST_LOAD:  state_next = ST_ROUND;
      ST_ROUND: if (t == 7'd63) state_next = ST_ADD;
      ST_ADD:   state_next = final_pass ? ST_OUT : (eom ? ST_PAD : ST_IDLE);
      ST_PAD:   if (ptr == 7'd63) state_next = ST_LOAD;
      ST_OUT:   if (out_ch.ready && oidx == 3'd7) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; count <= '0; oidx <= '0;
      final_pass <= 1'b0; second <= 1'b0; eom <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: if (in_ch.valid) begin
          eom <= in_ch.end_of_message; final_pass <= 1'b0; t <= '0;
          // marker goes where the next byte would; no length if it is past 55
          second <= (mark_pos >= 6'd56);
          ptr <= {1'b0, mark_pos};
          if (in_ch.carries_byte) begin
            buf_mem[count[5:2]][{~count[1:0], 3'b000} +: 8] <= in_ch.data_byte;
            count <= count + 61'd1;
          end
        end
        ST_LOAD: t <= '0;
        ST_ROUND: t <= t + 7'd1;
        ST_ADD: begin
          if (eom && !final_pass) begin
            second <= 1'b0; ptr <= 7'd0;
          end
        end
        ST_PAD: begin
          buf_mem[ptr[5:2]][{~ptr[1:0], 3'b000} +: 8] <= pad_val;
          if (ptr == 7'd63 && !second) final_pass <= 1'b1;
          ptr <= ptr + 7'd1;
        end
        ST_OUT: if (out_ch.ready) begin
          oidx <= oidx + 3'd1;
          if (oidx == 3'd7) count <= '0;
        end
        default: ;
      endcase
    end
  end

  `SHA_ASSERT(a_ready_idle, clk, rst, in_ch.ready |-> !out_ch.valid)
  `SHA_ASSERT(a_out_from_add, clk, rst, $rose(out_ch.valid) |-> $past(state) == ST_ADD)
  `SHA_ASSERT(a_word0_first, clk, rst, $rose(out_ch.valid) |-> oidx == 3'd0)
endmodule

// ----- dv/sha256_message_hash_checker.sv -----
// Checker for the SHA-256 message hash core: watches both channels, computes
// expected digests with its own SHA-256 model and compares every digest word.
// Depends on sha_if (sha_in_if, sha_out_if).
module sha256_message_hash_checker (
  input  logic    clk,
  input  logic    rst,
  sha_in_if.sink  in_mon,
  sha_out_if.sink out_mon,
  output int      fail_count,
  output int      pending_words,
  output int      digests_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        final_word;
  } digest_entry_t;

  localparam logic [31:0] IV [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
    32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
  localparam logic [31:0] KTAB [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

  logic [31:0]   chain [8];
  logic [7:0]    blk [64];
  logic [60:0]   byte_count;
  digest_entry_t expected_digest_q[$];

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = w[t-16] + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-7]
           + (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10));
    v = chain;
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[t] + w[t];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endtask

  task automatic absorb_request(input logic [7:0] b, input logic has_b, input logic last);
    int pos;
    logic [63:0] bits;
    digest_entry_t e;
    if (has_b) begin
      pos = int'(byte_count[5:0]);
      blk[pos] = b;
      byte_count++;
      if (pos == 63) compress();
    end
    if (last) begin
      pos = int'(byte_count[5:0]);
      blk[pos] = 8'h80;
      for (int i = pos + 1; i < 64; i++) blk[i] = 8'h00;
      if (pos >= 56) begin
        compress();
        for (int i = 0; i < 64; i++) blk[i] = 8'h00;
      end
      bits = {byte_count, 3'b000};
      for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
      compress();
      for (int i = 0; i < 8; i++) begin
        e.digest_word = chain[i];
        e.word_number = i[2:0];
        e.final_word = (i == 7);
        expected_digest_q.insert(expected_digest_q.size(), e);
      end
      chain = IV;
      byte_count = '0;
    end
  endtask

  always @(posedge clk) begin
    digest_entry_t e;
    if (rst) begin
      chain = IV;
      byte_count = '0;
      expected_digest_q.delete();
      fail_count = 0;
      digests_seen = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_digest_q.size() == 0) begin
          $error("unexpected digest word %h", out_mon.digest_word);
          fail_count++;
        end else begin
          e = expected_digest_q.pop_front();
          if (out_mon.digest_word !== e.digest_word) begin
            $error("digest_word exp %h got %h", e.digest_word, out_mon.digest_word);
            fail_count++;
          end
          if (out_mon.word_number !== e.word_number) begin
            $error("word_number exp %0d got %0d", e.word_number, out_mon.word_number);
            fail_count++;
          end
          if (out_mon.final_word !== e.final_word) begin
            $error("final_word exp %0d got %0d", e.final_word, out_mon.final_word);
            fail_count++;
          end
          if (e.final_word) digests_seen++;
        end
      end
      if (in_mon.valid && in_mon.ready)
        absorb_request(in_mon.data_byte, in_mon.carries_byte, in_mon.end_of_message);
    end
    pending_words = expected_digest_q.size();
  end
endmodule

// ----- dv/sha256_message_hash_core_test.sv -----
// Testbench top for the SHA-256 message hash core: clock, reset, request and
// ready stimulus, verdict. Depends on sha_pkg, sha_if, the core and the checker.
module sha256_message_hash_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 1500000;

  logic clk;
  logic rst;
  int   fail_count, pending_words, digests_seen;
  int   cycle_count;
  int   requests_sent;
  bit   long_hold;

  sha_in_if  in_ch (clk);
  sha_out_if out_ch (clk);

  sha256_message_hash_core DUT (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  sha256_message_hash_checker digest_checker (
    .clk(clk), .rst(rst), .in_mon(in_ch), .out_mon(out_ch),
    .fail_count(fail_count), .pending_words(pending_words), .digests_seen(digests_seen));

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [7:0] b, input logic has_b, input logic last);
    int gap;
    gap = $urandom_range(0, 11);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.carries_byte <= has_b;
    in_ch.end_of_message <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic send_message(input int len, input int mode);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: b = 8'h00;
        1: b = 8'hff;
        default: b = 8'($urandom_range(0, 255));
      endcase
      if ($urandom_range(0, 15) == 0)
        send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_request(b, 1'b1, (i == len - 1) && mode == 3);
    end
    if (mode != 3 || len == 0) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
  endtask

  initial begin
    int len;
    rst = 1'b1;
    long_hold = 1'b0;
    requests_sent = 0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.carries_byte = 1'b0;
    in_ch.end_of_message = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // empty, idle-then-empty, single bytes on the last request, three bytes then a bare end
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'hff, 1'b0, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'h00, 1'b1, 1'b1);
    send_request(8'hff, 1'b1, 1'b1);
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);
    drain();
    // padding boundaries: 55/56 bytes, full block, block plus two
    send_message(55, 2);
    send_message(56, 3);
    send_message(64, 1);
    send_message(66, 0);
    drain();
    long_hold = 1'b1;
    send_message(3, 2);
    send_message(2, 3);
    long_hold = 1'b0;
    drain();
    while (requests_sent < 320) begin
      case ($urandom_range(0, 3))
        0: len = $urandom_range(0, 3);
        1: len = $urandom_range(52, 70);
        2: len = $urandom_range(0, 20);
        default: len = $urandom_range(110, 130);
      endcase
      if (len > 330 - requests_sent) len = 330 - requests_sent;
      send_message(len, $urandom_range(0, 7) < 6 ? 2 + $urandom_range(0, 1)
                                                 : $urandom_range(0, 1));
      if ($urandom_range(0, 4) == 0) drain();
    end
    drain();
    repeat (300) @(posedge clk);
    $display("Sent %0d requests, checked %0d digests including boundary lengths,",
             requests_sent, digests_seen);
    $display("empty messages and stalled-output periods.");
    if (fail_count == 0 && pending_words == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    int wait_cycles;
    out_ch.ready = 1'b0;
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
        if (wait_cycles == 0) begin
          out_ch.ready <= 1'b1;
          @(posedge clk);
        end else begin
          out_ch.ready <= 1'b0;
          repeat (wait_cycles) @(posedge clk);
          out_ch.ready <= 1'b1;
          @(posedge clk);
        end
      end
    end
  end
endmodule

// ----- filelist.f -----
+incdir+design
design/sha_pkg.sv
design/sha_if.sv
design/sha_round.sv
design/sha256_message_hash_core.sv
dv/sha256_message_hash_checker.sv
dv/sha256_message_hash_core_test.sv
